/* sv/bdr_pkg.sv */
package bdr_pkg;

   // Defaults for the top-level parameters
   localparam int DEBOUNCE_LIMIT_DEFAULT = 8;
   localparam int SAMPLE_WIDTH_DEFAULT   = 12;

   // Register widths
   localparam int CFG_WIDTH       = 12;
   localparam int MARGIN_WIDTH    = 10;
   localparam int CSR_INDEX_WIDTH = 3;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0]    DIR_NEUTRAL_RESET   = 12'd2048;
   localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET        = 10'd20;
   localparam logic [CFG_WIDTH-1:0]    SPEED_NEUTRAL_RESET = 12'd2048;
   localparam logic [CFG_WIDTH-1:0]    SPEED_MIN_RESET     = 12'd2000;
   localparam logic [CFG_WIDTH-1:0]    SPEED_NEG_RESET     = 12'd1000;

   // Register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DIRECTION_NEUTRAL    = 3'd0,
      CSR_NEUTRAL_MARGIN       = 3'd1,
      CSR_SPEED_NEUTRAL        = 3'd2,
      CSR_SPEED_MIN_NEUTRAL    = 3'd3,
      CSR_SPEED_NEGATIVE_SCALE = 3'd4
   } csr_index_type;

   // Per-button control handed to a debouncer
   typedef struct packed {
      logic step;        // a sampling tick is taken this cycle
      logic force_open;  // hold the level open, keep the count
      logic pin;         // raw active-low sample
   } deb_ctrl_type;

endpackage

/* sv/bdr_debounce.sv */
module bdr_debounce #(
   parameter int DEBOUNCE_LIMIT = bdr_pkg::DEBOUNCE_LIMIT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bdr_pkg::deb_ctrl_type ctrl,
   output logic                 level_in
);

   // Incremented count reaches DEBOUNCE_LIMIT + 1 at most
   localparam int CW = $clog2(DEBOUNCE_LIMIT + 2);
   localparam logic [CW-1:0] LIMIT_C = CW'(DEBOUNCE_LIMIT);

   logic          level_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_inc;

   assign count_inc = count_ff + 1'b1;

   // Next level and count for this tick
   always_comb begin
      level_in = level_ff;
      count_in = count_ff;
      if (ctrl.force_open) begin
         level_in = 1'b1;
      end else if (ctrl.pin == level_ff) begin
         count_in = '0;
      end else if (count_inc > LIMIT_C) begin
         level_in = ctrl.pin;
         count_in = '0;
      end else begin
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b1;
         count_ff <= '0;
      end else if (ctrl.step) begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

/* sv/button_debounce_with_reverse_mode.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    three button pins, two DIP pins, speed, direction
// rsp      out        rsp_valid/rsp_ready    cal, user, mode active; DIP 1 and DIP 2 closed
// csr      in         csr_valid/csr_ready    csr_index, csr_data (write only)
//
// One transaction per cycle unless stalled; the result appears the cycle after acceptance.
// The debounce counters and the reverse window compare settle in one pass
// ahead of the result register; req_ready drops only while a result is held.
// Synchronous reset opens all buttons, clears counts and loads register defaults.
// csr_ready is always high; writes to an index beyond the map are dropped.
module button_debounce_with_reverse_mode #(
   parameter int DEBOUNCE_LIMIT = bdr_pkg::DEBOUNCE_LIMIT_DEFAULT,
   parameter int SAMPLE_WIDTH   = bdr_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cal_pin,
   input  logic                                req_mode_pin,
   input  logic                                req_user_pin,
   input  logic                                req_dip_reverse_pin,
   input  logic                                req_dip_disable_pin,
   input  logic [SAMPLE_WIDTH-1:0]             req_speed_sample,
   input  logic [SAMPLE_WIDTH-1:0]             req_direction_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_cal_active,
   output logic                                rsp_user_active,
   output logic                                rsp_mode_active,
   output logic                                rsp_dip_reverse_closed,
   output logic                                rsp_dip_disable_closed,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bdr_pkg::CFG_WIDTH-1:0]       csr_data
);

   localparam int CFG_W = bdr_pkg::CFG_WIDTH;
   localparam int MAR_W = bdr_pkg::MARGIN_WIDTH;
   // Signed width that holds every sum and difference without wrap
   localparam int AW = ((SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W) + 2;

   logic accept;

   // Configuration registers
   logic [CFG_W-1:0] dir_neutral_ff;
   logic [MAR_W-1:0] margin_ff;
   logic [CFG_W-1:0] speed_neutral_ff;
   logic [CFG_W-1:0] speed_min_ff;
   logic [CFG_W-1:0] speed_neg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_neutral_ff   <= bdr_pkg::DIR_NEUTRAL_RESET;
         margin_ff        <= bdr_pkg::MARGIN_RESET;
         speed_neutral_ff <= bdr_pkg::SPEED_NEUTRAL_RESET;
         speed_min_ff     <= bdr_pkg::SPEED_MIN_RESET;
         speed_neg_ff     <= bdr_pkg::SPEED_NEG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (bdr_pkg::csr_index_type'(csr_index))
            bdr_pkg::CSR_DIRECTION_NEUTRAL:    dir_neutral_ff   <= csr_data;
            bdr_pkg::CSR_NEUTRAL_MARGIN:       margin_ff        <= csr_data[MAR_W-1:0];
            bdr_pkg::CSR_SPEED_NEUTRAL:        speed_neutral_ff <= csr_data;
            bdr_pkg::CSR_SPEED_MIN_NEUTRAL:    speed_min_ff     <= csr_data;
            bdr_pkg::CSR_SPEED_NEGATIVE_SCALE: speed_neg_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Handshake: take a transaction unless a result is stuck
   logic rsp_valid_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Button debouncers
   bdr_pkg::deb_ctrl_type cal_ctrl;
   bdr_pkg::deb_ctrl_type mode_ctrl;
   bdr_pkg::deb_ctrl_type user_ctrl;
   logic cal_level_in;
   logic mode_level_in;
   logic user_level_in;

   assign cal_ctrl  = '{step: accept, force_open: 1'b0, pin: req_cal_pin};
   assign mode_ctrl = '{step: accept, force_open: !req_dip_disable_pin, pin: req_mode_pin};
   assign user_ctrl = '{step: accept, force_open: 1'b0, pin: req_user_pin};

   bdr_debounce #(.DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)) u_cal_deb (
      .clock(clock), .reset(reset), .ctrl(cal_ctrl), .level_in(cal_level_in)
   );

   bdr_debounce #(.DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)) u_mode_deb (
      .clock(clock), .reset(reset), .ctrl(mode_ctrl), .level_in(mode_level_in)
   );

   bdr_debounce #(.DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)) u_user_deb (
      .clock(clock), .reset(reset), .ctrl(user_ctrl), .level_in(user_level_in)
   );

   // Reverse deflection rule, all in signed AW bits
   logic signed [AW-1:0] speed_s;
   logic signed [AW-1:0] dir_s;
   logic signed [AW-1:0] dn_s;
   logic signed [AW-1:0] win_s;
   logic signed [AW-1:0] sn_s;
   logic signed [AW-1:0] smin_s;
   logic signed [AW-1:0] ns_s;
   logic signed [AW-1:0] ns_half_s;
   logic signed [AW-1:0] floor_s;
   logic signed [AW-1:0] speed_clamp_s;
   logic signed [AW-1:0] deflection_s;
   logic                 dir_in_window;
   logic                 reverse_hit;

   always_comb begin
      speed_s   = $signed({{(AW-SAMPLE_WIDTH){1'b0}}, req_speed_sample});
      dir_s     = $signed({{(AW-SAMPLE_WIDTH){1'b0}}, req_direction_sample});
      dn_s      = $signed({{(AW-CFG_W){1'b0}}, dir_neutral_ff});
      win_s     = $signed({{(AW-MAR_W-1){1'b0}}, margin_ff, 1'b0});
      sn_s      = $signed({{(AW-CFG_W){1'b0}}, speed_neutral_ff});
      smin_s    = $signed({{(AW-CFG_W){1'b0}}, speed_min_ff});
      ns_s      = $signed({{(AW-CFG_W){1'b0}}, speed_neg_ff});
      ns_half_s = $signed({{(AW-CFG_W+1){1'b0}}, speed_neg_ff[CFG_W-1:1]});

      floor_s       = sn_s - ns_s;
      speed_clamp_s = (speed_s < floor_s) ? floor_s : speed_s;
      deflection_s  = sn_s - speed_clamp_s;

      dir_in_window = (dir_s > (dn_s - win_s)) && (dir_s < (dn_s + win_s));
      reverse_hit   = !req_dip_reverse_pin && dir_in_window && (speed_s < smin_s)
                      && (deflection_s > ns_half_s);
   end

   // Result register
   logic rsp_cal_ff;
   logic rsp_user_ff;
   logic rsp_mode_ff;
   logic rsp_dip_rev_ff;
   logic rsp_dip_dis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_cal_ff     <= !cal_level_in;
         rsp_user_ff    <= !user_level_in;
         rsp_mode_ff    <= !mode_level_in || reverse_hit;
         rsp_dip_rev_ff <= !req_dip_reverse_pin;
         rsp_dip_dis_ff <= !req_dip_disable_pin;
      end
   end

   assign rsp_cal_active         = rsp_cal_ff;
   assign rsp_user_active        = rsp_user_ff;
   assign rsp_mode_active        = rsp_mode_ff;
   assign rsp_dip_reverse_closed = rsp_dip_rev_ff;
   assign rsp_dip_disable_closed = rsp_dip_dis_ff;

endmodule

/* sv/bdr_checker.sv */
module bdr_protocol_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_dip_reverse_pin,
   input logic req_dip_disable_pin,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_cal_active,
   input logic rsp_user_active,
   input logic rsp_mode_active,
   input logic rsp_dip_reverse_closed,
   input logic rsp_dip_disable_closed
);

   // A stalled result stays valid and holds its button flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_active)
      && $stable(rsp_cal_active) && $stable(rsp_user_active))
      else $error("stalled result changed");

   // Every accepted transaction shows a result next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction gave no result");

   // Input side stalls only while a result waits
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the result stage");

   // DIP states reach the result inverted, as closed flags
   a_dip_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_dip_reverse_closed == !$past(req_dip_reverse_pin)
      && rsp_dip_disable_closed == !$past(req_dip_disable_pin))
      else $error("DIP state lost on the way to the result");

   // Nothing is pending after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind button_debounce_with_reverse_mode bdr_protocol_checker u_checker (.*);
